/* src/lfu_pkg.sv */
`default_nettype none

package lfu_pkg;

    // fixed field widths
    localparam int CAND_W     = 7;
    localparam int SLOT_W     = 6;
    localparam int STAMP_W    = 32;
    localparam int OUT_VOTE_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // board size limits
    localparam logic [SLOT_W-1:0] MAX_SLOTS      = 6'd32;
    localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST = 6'd3;

    // opcodes carried in s_tuser
    localparam logic OP_RECOMMEND = 1'b0;
    localparam logic OP_LIST      = 1'b1;

    // one result beat
    typedef struct packed {
        logic                  last;
        logic [OUT_VOTE_W-1:0] listed_votes;
        logic [CAND_W-1:0]     listed_id;
        logic [CAND_W-1:0]     evicted_id;
        logic                  evicted;
        logic                  hit;
    } res_t;

    // sequencer states
    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LOOK  = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_EVICT = 8'b0001_0000,
        ST_PLACE = 8'b0010_0000,
        ST_RESP  = 8'b0100_0000,
        ST_LEND  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

/* src/lfu_table.sv */
`default_nettype none

module lfu_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int VW    = 16,
    parameter int SW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [VW-1:0] wvotes,
    input  wire logic [SW-1:0] wstamp,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [VW-1:0] rvotes,
    output logic      [SW-1:0] rstamp
);

    logic [SW+VW-1:0] mem [DEPTH];
    logic [SW+VW-1:0] rdata_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wstamp, wvotes};
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rvotes = rdata_reg[VW-1:0];
    assign rstamp = rdata_reg[SW+VW-1:VW];

endmodule

`default_nettype wire

/* src/lfu_out_reg.sv */
`default_nettype none

module lfu_out_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire lfu_pkg::res_t                 res,
    output logic                               free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lfu_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    import lfu_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // room for a new beat once the held one leaves
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.listed_votes, res_reg.listed_id, res_reg.evicted_id,
                       res_reg.evicted, res_reg.hit};
    assign m_tlast  = res_reg.last;

endmodule

`default_nettype wire

/* src/lfu_board_with_oldest_tiebreak_core.sv */
// recommend hit: ST_LOOK, then ST_RESP; bad id: ST_RESP directly; miss with a free slot:
// ST_LOOK, ST_PLACE, ST_RESP; full-board miss: a victim search with one table read per id,
// then ST_EVICT, ST_PLACE, ST_RESP; list: one table read per id, can stall while m_tready is low
// one item at a time; the single read port of the id table sets the scan length
// reset: synchronous, active low; then a clearing pass writes every id once and empties the
// table, with s_tready low until it ends
`default_nettype none

module lfu_board_with_oldest_tiebreak_core #(
    parameter int ID_COUNT  = 128,
    parameter int VOTE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // slot_limit
    input  wire logic                          cfg_we,
    input  wire logic [lfu_pkg::SLOT_W-1:0]    cfg_wdata,
    // s_tdata: candidate_id [6:0], bit 7 zero; s_tuser: op
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lfu_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    // m_tdata: hit [0], evicted [1], evicted_id [8:2], listed_id [15:9],
    // listed_votes [31:16]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lfu_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    import lfu_pkg::*;

    localparam int IDW = $clog2(ID_COUNT);
    localparam int PW  = IDW + 1;
    localparam int CW  = (PW > CAND_W) ? PW : CAND_W;
    localparam logic [PW-1:0] PTR_END  = PW'(ID_COUNT);
    localparam logic [PW-1:0] PTR_LAST = PW'(ID_COUNT - 1);

    state_t                 state_reg,      state_next;
    logic [PW-1:0]          ptr_reg,        ptr_next;
    logic                   dv_reg,         dv_next;
    logic [IDW-1:0]         chk_reg,        chk_next;
    logic                   list_reg,       list_next;
    logic                   found_reg,      found_next;
    logic [IDW-1:0]         best_id_reg,    best_id_next;
    logic [VOTE_BITS-1:0]   best_votes_reg, best_votes_next;
    logic [STAMP_W-1:0]     best_stamp_reg, best_stamp_next;
    logic                   pend_reg,       pend_next;
    logic [IDW-1:0]         pend_id_reg,    pend_id_next;
    logic [VOTE_BITS-1:0]   pend_votes_reg, pend_votes_next;
    logic [SLOT_W-1:0]      n_reg,          n_next;
    logic [SLOT_W-1:0]      occ_reg,        occ_next;
    logic [STAMP_W-1:0]     stamp_cnt_reg,  stamp_cnt_next;
    logic [STAMP_W-1:0]     stamp_reg,      stamp_next;
    logic [IDW-1:0]         cand_reg,       cand_next;
    logic                   hit_reg,        hit_next;
    logic [SLOT_W-1:0]      limit_reg;

    logic [CW-1:0]          cand_ext;
    logic                   id_ok;
    logic [SLOT_W-1:0]      eff_limit;
    logic                   tbl_we;
    logic [IDW-1:0]         tbl_waddr;
    logic [VOTE_BITS-1:0]   tbl_wvotes;
    logic [STAMP_W-1:0]     tbl_wstamp;
    logic                   tbl_re;
    logic [IDW-1:0]         tbl_raddr;
    logic [VOTE_BITS-1:0]   rd_votes;
    logic [STAMP_W-1:0]     rd_stamp;
    logic                   rd_nz;
    logic                   better;
    logic                   stall;
    logic                   issue;
    logic                   out_load;
    logic                   out_free;
    res_t                   out_res;

    // id table: vote count and arrival stamp per id
    lfu_table #(
        .DEPTH (ID_COUNT),
        .AW    (IDW),
        .VW    (VOTE_BITS),
        .SW    (STAMP_W)
    ) u_table (
        .aclk   (aclk),
        .we     (tbl_we),
        .waddr  (tbl_waddr),
        .wvotes (tbl_wvotes),
        .wstamp (tbl_wstamp),
        .re     (tbl_re),
        .raddr  (tbl_raddr),
        .rvotes (rd_votes),
        .rstamp (rd_stamp)
    );

    // result register towards the master side
    lfu_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .res      (out_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // slot limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= SLOT_LIMIT_RST;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // zero acts as one, above the board size acts as the board size
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = SLOT_W'(1);
        end else if (limit_reg > MAX_SLOTS) begin
            eff_limit = MAX_SLOTS;
        end else begin
            eff_limit = limit_reg;
        end
    end

    assign cand_ext = CW'(s_tdata[CAND_W-1:0]);
    assign id_ok    = (cand_ext != '0) && (cand_ext < CW'(ID_COUNT));
    assign s_tready = (state_reg == ST_IDLE);

    // scan datapath: fewest votes first, then oldest stamp, then lowest id
    assign rd_nz  = (rd_votes != '0);
    assign better = !found_reg || (rd_votes < best_votes_reg) ||
                    ((rd_votes == best_votes_reg) && (rd_stamp < best_stamp_reg));
    assign stall  = list_reg && dv_reg && rd_nz && pend_reg && !out_free;
    assign issue  = (ptr_reg < PTR_END) && !stall;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        dv_next         = dv_reg;
        chk_next        = chk_reg;
        list_next       = list_reg;
        found_next      = found_reg;
        best_id_next    = best_id_reg;
        best_votes_next = best_votes_reg;
        best_stamp_next = best_stamp_reg;
        pend_next       = pend_reg;
        pend_id_next    = pend_id_reg;
        pend_votes_next = pend_votes_reg;
        n_next          = n_reg;
        occ_next        = occ_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        stamp_next      = stamp_reg;
        cand_next       = cand_reg;
        hit_next        = hit_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = cand_reg;
        tbl_wvotes      = '0;
        tbl_wstamp      = '0;
        tbl_re          = 1'b0;
        tbl_raddr       = ptr_reg[IDW-1:0];
        out_load        = 1'b0;
        out_res         = '0;

        case (state_reg)
            // clearing pass over the table after reset
            ST_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = ptr_reg[IDW-1:0];
                ptr_next  = ptr_reg + PW'(1);
                if (ptr_reg == PTR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            // take one beat
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_LIST) begin
                        list_next  = 1'b1;
                        ptr_next   = PW'(1);
                        dv_next    = 1'b0;
                        n_next     = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end else begin
                        stamp_next   = stamp_cnt_reg;
                        if (stamp_cnt_reg != '1) begin
                            stamp_cnt_next = stamp_cnt_reg + STAMP_W'(1);
                        end
                        hit_next     = 1'b0;
                        found_next   = 1'b0;
                        best_id_next = '0;
                        cand_next    = IDW'(cand_ext);
                        if (id_ok) begin
                            tbl_re     = 1'b1;
                            tbl_raddr  = IDW'(cand_ext);
                            state_next = ST_LOOK;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            // entry of the candidate is in the read register
            ST_LOOK: begin
                if (rd_nz) begin
                    tbl_we     = 1'b1;
                    tbl_wvotes = (&rd_votes) ? rd_votes : rd_votes + VOTE_BITS'(1);
                    tbl_wstamp = rd_stamp;
                    hit_next   = 1'b1;
                    state_next = ST_RESP;
                end else if (occ_reg >= eff_limit) begin
                    list_next  = 1'b0;
                    ptr_next   = PW'(1);
                    dv_next    = 1'b0;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_PLACE;
                end
            end

            // pipelined pass over ids 1 and up, one read a cycle unless stalled by the result register
            ST_SCAN: begin
                if (!stall) begin
                    tbl_re   = issue;
                    dv_next  = issue;
                    chk_next = ptr_reg[IDW-1:0];
                    if (issue) begin
                        ptr_next = ptr_reg + PW'(1);
                    end
                end
                if (dv_reg && !stall && rd_nz) begin
                    if (list_reg) begin
                        // send the held entry now that another follows
                        if (pend_reg) begin
                            out_load             = 1'b1;
                            out_res.listed_id    = CAND_W'(pend_id_reg);
                            out_res.listed_votes = OUT_VOTE_W'(pend_votes_reg);
                        end
                        pend_next       = 1'b1;
                        pend_id_next    = chk_reg;
                        pend_votes_next = rd_votes;
                        n_next          = n_reg + SLOT_W'(1);
                        if (n_reg + SLOT_W'(1) == MAX_SLOTS) begin
                            dv_next    = 1'b0;
                            state_next = ST_LEND;
                        end
                    end else if (better) begin
                        found_next      = 1'b1;
                        best_id_next    = chk_reg;
                        best_votes_next = rd_votes;
                        best_stamp_next = rd_stamp;
                    end
                end
                if (!dv_reg && (ptr_reg == PTR_END)) begin
                    if (list_reg) begin
                        state_next = ST_LEND;
                    end else if (found_reg) begin
                        state_next = ST_EVICT;
                    end else begin
                        state_next = ST_PLACE;
                    end
                end
            end

            // drop the victim
            ST_EVICT: begin
                tbl_we     = 1'b1;
                tbl_waddr  = best_id_reg;
                tbl_wstamp = best_stamp_reg;
                occ_next   = occ_reg - SLOT_W'(1);
                state_next = ST_PLACE;
            end

            // place the candidate with one vote
            ST_PLACE: begin
                tbl_we     = 1'b1;
                tbl_wvotes = VOTE_BITS'(1);
                tbl_wstamp = stamp_reg;
                occ_next   = occ_reg + SLOT_W'(1);
                state_next = ST_RESP;
            end

            // recommend result
            ST_RESP: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_res.hit        = hit_reg;
                    out_res.evicted    = found_reg;
                    out_res.evicted_id = CAND_W'(best_id_reg);
                    out_res.last       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            // final list beat, or the empty-board beat
            ST_LEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_reg) begin
                        out_res.listed_id    = CAND_W'(pend_id_reg);
                        out_res.listed_votes = OUT_VOTE_W'(pend_votes_reg);
                    end
                    out_res.last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            dv_reg        <= 1'b0;
            occ_reg       <= '0;
            stamp_cnt_reg <= '0;
            list_reg      <= 1'b0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            n_reg         <= '0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            dv_reg        <= dv_next;
            occ_reg       <= occ_next;
            stamp_cnt_reg <= stamp_cnt_next;
            list_reg      <= list_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            n_reg         <= n_next;
            hit_reg       <= hit_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        chk_reg        <= chk_next;
        best_id_reg    <= best_id_next;
        best_votes_reg <= best_votes_next;
        best_stamp_reg <= best_stamp_next;
        pend_id_reg    <= pend_id_next;
        pend_votes_reg <= pend_votes_next;
        stamp_reg      <= stamp_next;
        cand_reg       <= cand_next;
    end

endmodule

`default_nettype wire

/* src/lfu_chk.sv */
`default_nettype none

module lfu_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a hit is a single closing beat with no eviction
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tlast && !m_tdata[1])
        else $error("hit beat malformed");

    // an eviction names a real id
    a_evid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[8:2] != 7'd0)
        else $error("eviction without id");

    // a listing beat carries no recommend flags
    a_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:9] != 7'd0 |-> m_tdata[1:0] == 2'b00)
        else $error("listing beat with recommend flags");

endmodule

bind lfu_board_with_oldest_tiebreak_core lfu_chk u_lfu_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
